// File: sv/dtq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtq_pkg
// Shared types, sizes and codes of the deadline timer queue.
// ----------------------------------------------------------------------------
package dtq_pkg;

  localparam int SLOTS = 16;                 // timer store depth, 2..256
  localparam int IW    = $clog2(SLOTS);      // slot address width
  localparam int CW    = $clog2(SLOTS + 1);  // live count width

  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 32;

  typedef logic [IW-1:0] slot_t;
  typedef logic [CW-1:0] cnt_t;

  typedef struct packed {
    logic [63:0]        dl;
    logic signed [31:0] tg;
  } entry_t;

  typedef enum logic [1:0] {
    KIND_EXPIRED  = 2'd0,
    KIND_TICK     = 2'd1,
    KIND_ADDED    = 2'd2,
    KIND_REJECTED = 2'd3
  } kind_e;

  typedef enum logic {
    CMD_ADD  = 1'b0,
    CMD_TICK = 1'b1
  } cmd_e;

  localparam logic [CFG_IDX_W-1:0] REG_MARKER = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD = CFG_IDX_W'(1);

  // Circular store: physical slot of logical offset off from head h.
  function automatic slot_t slot_addr(input slot_t h, input cnt_t off);
    logic [CW:0] s;
    s = {{(CW + 1 - IW){1'b0}}, h} + {1'b0, off};
    if (s >= (CW + 1)'(SLOTS)) begin
      s = s - (CW + 1)'(SLOTS);
    end
    return s[IW-1:0];
  endfunction

endpackage

// File: sv/dtq_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtq_if
// Valid/ready channels of the deadline timer queue: input, result, config.
// ----------------------------------------------------------------------------
interface dtq_in_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic [63:0]        deadline;
  logic signed [31:0] tag;
  modport source (output valid, command, deadline, tag, input ready);
  modport sink   (input valid, command, deadline, tag, output ready);
endinterface

interface dtq_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [63:0]        expired_deadline;
  logic signed [31:0] expired_tag;
  logic               task_switch;
  logic [63:0]        current_tick;
  logic               last;
  modport source (output valid, kind, expired_deadline, expired_tag, task_switch,
                  current_tick, last, input ready);
  modport sink   (input valid, kind, expired_deadline, expired_tag, task_switch,
                  current_tick, last, output ready);
endinterface

interface dtq_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [dtq_pkg::CFG_IDX_W-1:0]  index;
  logic [dtq_pkg::CFG_DAT_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: sv/dtq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtq_ram
// Generic 1R1W synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
module dtq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/deadline_timer_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deadline_timer_queue
// Earliest-deadline timer store in a circular RAM, with tick-driven expiry.
// ----------------------------------------------------------------------------
//  port   | dir | word
//  -------+-----+---------------------------------------------------------
//  in_i   | in  | command, deadline, tag
//  out_o  | out | kind, expired_deadline, expired_tag, task_switch,
//         |     | current_tick, last
//  cfg_i  | in  | index (0 task marker tag, 1 task period), data
//
//  One word at a time. An add walks down from the tail, moving each later
//  entry up one slot (one RAM read, one write a step) until it stops above
//  an older entry or at the head. A tick emits each expired timer, re-arms
//  the task timer by the same insert walk and ends with a summary. The
//  single RAM read port serializes these steps. Reset clears live count,
//  head, tick counter; config takes its defaults; RAM stays undefined.
//  A result word waiting in the output register holds the sequencer.
// ----------------------------------------------------------------------------
module deadline_timer_queue (
  input  logic clk_i,
  input  logic rst_ni,
  dtq_in_if.sink    in_i,
  dtq_out_if.source out_o,
  dtq_cfg_if.sink   cfg_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS,     // issue read of the neighbor below the insert point, or place at head
    ST_INS_W,   // compare, shift up or place new entry
    ST_TCHK,    // read head entry
    ST_TCMP,    // expired? pop it
    ST_EMIT,    // deliver expired timer
    ST_SUM,     // deliver tick summary
    ST_RESP     // deliver add answer
  } state_e;

  localparam dtq_pkg::cnt_t SLOTS_C = dtq_pkg::CW'(dtq_pkg::SLOTS);
  localparam dtq_pkg::cnt_t ONE_C   = dtq_pkg::CW'(1);

  state_e             state_q;
  dtq_pkg::slot_t     head_q;     // physical slot of earliest timer
  dtq_pkg::cnt_t      live_q;     // live entries
  dtq_pkg::cnt_t      pos_q;      // logical insert position
  dtq_pkg::cnt_t      rem_q;      // entries present at tick start, still unchecked
  logic [63:0]        tick_q;
  logic signed [31:0] marker_q;
  logic [15:0]        period_q;
  logic               sw_q;       // task timer fired this tick
  logic               ret_tick_q; // insert belongs to a tick
  dtq_pkg::entry_t    ins_q;      // entry being inserted
  dtq_pkg::entry_t    exp_q;      // expired entry awaiting delivery
  dtq_pkg::kind_e     resp_q;

  // Result register
  logic               out_valid_q;
  dtq_pkg::kind_e     kind_q;
  logic [63:0]        odl_q;
  logic signed [31:0] otg_q;
  logic               osw_q;
  logic [63:0]        otick_q;
  logic               olast_q;

  // RAM ports
  logic                   re, we;
  dtq_pkg::slot_t         raddr, waddr;
  dtq_pkg::entry_t        wdata, rdata;
  logic [$bits(dtq_pkg::entry_t)-1:0] rdata_raw;

  logic        slot_free;
  logic        out_load;
  logic        shift_up;
  logic [15:0] per_eff;
  logic [64:0] rearm_sum;
  logic [63:0] rearm_dl;

  dtq_ram #(
    .WIDTH ($bits(dtq_pkg::entry_t)),
    .DEPTH (dtq_pkg::SLOTS),
    .AW    (dtq_pkg::IW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata_raw)
  );

  assign rdata     = dtq_pkg::entry_t'(rdata_raw);
  assign slot_free = !out_valid_q || out_o.ready;
  assign out_load  = slot_free &&
                     (state_q == ST_EMIT || state_q == ST_SUM || state_q == ST_RESP);
  assign shift_up  = rdata.dl > ins_q.dl;

  // Zero period acts as one; re-arm deadline saturates.
  assign per_eff   = (period_q == 16'd0) ? 16'd1 : period_q;
  assign rearm_sum = {1'b0, tick_q} + {49'd0, per_eff};
  assign rearm_dl  = rearm_sum[64] ? {64{1'b1}} : rearm_sum[63:0];

  // RAM access per state. Writes always land above the next read, so the
  // read-modify-write walk needs no forwarding.
  always_comb begin
    re    = 1'b0;
    we    = 1'b0;
    raddr = head_q;
    waddr = dtq_pkg::slot_addr(head_q, pos_q);
    wdata = ins_q;
    case (state_q)
      ST_INS: begin
        if (pos_q != '0) begin
          re    = 1'b1;
          raddr = dtq_pkg::slot_addr(head_q, pos_q - ONE_C);
        end else begin
          we = 1'b1;
        end
      end
      ST_INS_W: begin
        we    = 1'b1;
        wdata = shift_up ? rdata : ins_q;
      end
      ST_TCHK: begin
        re = (rem_q != '0);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      live_q      <= '0;
      tick_q      <= '0;
      marker_q    <= 32'sh8000_0000;
      period_q    <= 16'd2;
      sw_q        <= 1'b0;
      ret_tick_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_i.valid) begin
        if (cfg_i.index == dtq_pkg::REG_MARKER) begin
          marker_q <= $signed(cfg_i.data);
        end else if (cfg_i.index == dtq_pkg::REG_PERIOD) begin
          period_q <= cfg_i.data[15:0];
        end
      end

      case (state_q)
        ST_IDLE: begin
          if (in_i.valid) begin
            if (in_i.command == dtq_pkg::CMD_TICK) begin
              tick_q  <= tick_q + 64'd1;
              sw_q    <= 1'b0;
              rem_q   <= live_q;
              state_q <= ST_TCHK;
            end else if (live_q == SLOTS_C) begin
              resp_q  <= dtq_pkg::KIND_REJECTED;
              state_q <= ST_RESP;
            end else begin
              ins_q.dl   <= in_i.deadline;
              ins_q.tg   <= in_i.tag;
              pos_q      <= live_q;
              ret_tick_q <= 1'b0;
              state_q    <= ST_INS;
            end
          end
        end
        ST_INS: begin
          if (pos_q == '0) begin
            live_q  <= live_q + ONE_C;
            resp_q  <= dtq_pkg::KIND_ADDED;
            state_q <= ret_tick_q ? ST_TCHK : ST_RESP;
          end else begin
            state_q <= ST_INS_W;
          end
        end
        ST_INS_W: begin
          if (shift_up) begin
            pos_q   <= pos_q - ONE_C;
            state_q <= ST_INS;
          end else begin
            live_q  <= live_q + ONE_C;
            resp_q  <= dtq_pkg::KIND_ADDED;
            state_q <= ret_tick_q ? ST_TCHK : ST_RESP;
          end
        end
        ST_TCHK: begin
          state_q <= (rem_q != '0) ? ST_TCMP : ST_SUM;
        end
        ST_TCMP: begin
          if (rdata.dl <= tick_q) begin
            head_q <= dtq_pkg::slot_addr(head_q, ONE_C);
            live_q <= live_q - ONE_C;
            rem_q  <= rem_q - ONE_C;
            if (rdata.tg == marker_q) begin
              // Re-armed deadline is at or past the tick, so it lands behind
              // the remaining expired prefix; rem_q ends the pass before it.
              sw_q       <= 1'b1;
              ins_q.dl   <= rearm_dl;
              ins_q.tg   <= marker_q;
              pos_q      <= live_q - ONE_C;
              ret_tick_q <= 1'b1;
              state_q    <= ST_INS;
            end else begin
              exp_q   <= rdata;
              state_q <= ST_EMIT;
            end
          end else begin
            state_q <= ST_SUM;
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            kind_q      <= dtq_pkg::KIND_EXPIRED;
            odl_q       <= exp_q.dl;
            otg_q       <= exp_q.tg;
            osw_q       <= 1'b0;
            otick_q     <= tick_q;
            olast_q     <= 1'b0;
            state_q     <= ST_TCHK;
          end
        end
        ST_SUM: begin
          if (slot_free) begin
            kind_q      <= dtq_pkg::KIND_TICK;
            odl_q       <= '0;
            otg_q       <= '0;
            osw_q       <= sw_q;
            otick_q     <= tick_q;
            olast_q     <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        ST_RESP: begin
          if (slot_free) begin
            kind_q      <= resp_q;
            odl_q       <= '0;
            otg_q       <= '0;
            osw_q       <= 1'b0;
            otick_q     <= tick_q;
            olast_q     <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_i.ready   = (state_q == ST_IDLE);
  assign cfg_i.ready  = 1'b1;

  assign out_o.valid            = out_valid_q;
  assign out_o.kind             = kind_q;
  assign out_o.expired_deadline = odl_q;
  assign out_o.expired_tag      = otg_q;
  assign out_o.task_switch      = osw_q;
  assign out_o.current_tick     = otick_q;
  assign out_o.last             = olast_q;

`ifndef ASSERT_OFF
  a_live_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    live_q <= SLOTS_C)
    else $error("live count above store depth");

  a_ram_write_only_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (state_q == ST_INS || state_q == ST_INS_W))
    else $error("RAM written outside insert");

  a_no_insert_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INS) |-> (live_q != SLOTS_C))
    else $error("insert into full store");

  a_pop_advances_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TCMP && rdata.dl <= tick_q) |=>
      (live_q == $past(live_q) - ONE_C))
    else $error("expired pop did not shrink store");
`endif

endmodule
